// ===== rtl/pa_pkg.sv =====
// shared widths, operation codes, status codes and register indexes of the page allocator
`default_nettype none

package pa_pkg;

    // payload widths
    localparam int OP_W       = 3;
    localparam int ADDR_W     = 28;
    localparam int DELTA_W    = 8;
    localparam int VALUE_W    = 8;
    localparam int FCOUNT_W   = 17;
    localparam int STATUS_W   = 3;

    // configuration port
    localparam int FIRST_W    = 16;
    localparam int LIMIT_W    = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'd1;

    localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = 17'd57344;

    // operations
    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_MEMORY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT_NOT_ONE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE_TABLE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL    = 3'd5;

endpackage

`default_nettype wire

// ===== rtl/pa_req_if.sv =====
// request channel of the page allocator
`default_nettype none

interface pa_req_if
    import pa_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [ADDR_W-1:0]         byte_address;
    logic signed [DELTA_W-1:0] ref_delta;

    modport source (output valid, output operation, output byte_address, output ref_delta,
                    input ready);
    modport sink   (input valid, input operation, input byte_address, input ref_delta,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pa_rsp_if.sv =====
// response channel of the page allocator
`default_nettype none

interface pa_rsp_if
    import pa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   page_address;
    logic [VALUE_W-1:0]  ref_value;
    logic [FCOUNT_W-1:0] free_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output page_address, output ref_value, output free_count,
                    output status, input ready);
    modport sink   (input valid, input page_address, input ref_value, input free_count,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/pa_ref_store.sv =====
// reference count memory with registered read and a range clearing sweep
`default_nettype none

module pa_ref_store
    import pa_pkg::*;
#(
    parameter int NUM_PAGES = 65536,
    parameter int REF_BITS  = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(NUM_PAGES)-1:0]    rd_addr,
    output logic [REF_BITS-1:0]             rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(NUM_PAGES)-1:0]    wr_addr,
    input  logic [REF_BITS-1:0]             wr_data,
    input  logic                            clr_start,
    input  logic [$clog2(NUM_PAGES+1)-1:0]  clr_first,
    input  logic [$clog2(NUM_PAGES+1)-1:0]  clr_limit,
    output logic                            busy
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);

    logic [REF_BITS-1:0] mem [NUM_PAGES];

    logic [CNT_W-1:0] clr_ptr_reg, clr_ptr_next;
    logic [CNT_W-1:0] clr_end_reg, clr_end_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] clr_ptr_inc;

    assign clr_ptr_inc = clr_ptr_reg + CNT_W'(1);
    assign busy        = busy_reg;

    always_comb
    begin
        clr_ptr_next = clr_ptr_reg;
        clr_end_next = clr_end_reg;
        busy_next    = busy_reg;
        priority if (busy_reg)
        begin
            clr_ptr_next = clr_ptr_inc;
            if (clr_ptr_inc == clr_end_reg)
            begin
                busy_next = 1'b0;
            end
        end
        else if (clr_start)
        begin
            clr_ptr_next = clr_first;
            clr_end_next = clr_limit;
            busy_next    = 1'b1;
        end
    end

    // the whole table is swept once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
            clr_end_reg <= CNT_W'(NUM_PAGES);
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_ptr_reg <= clr_ptr_next;
            clr_end_reg <= clr_end_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (busy_reg)
        begin
            mem[clr_ptr_reg[IDX_W-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/page_allocator_with_refcounts.sv =====
// top level of the page allocator with per-page reference counts
`default_nettype none

// LIFO page allocator. Each request transaction (init, allocate, free, add
// references, read count) yields exactly one response transaction carrying
// the allocated page address, the resulting reference count, the free page
// count and a status code. In the accept cycle the reference count memory
// and the freed-page stack memory are read (registered reads); in the execute
// step, which waits while an earlier response is still held, the entry is
// modified, written back and the response register is loaded. Ready is low
// during the execute step, so a new request is taken only after it. The
// response register lets the next request be taken while a response still
// waits. Init additionally clears the counts of pages first_page .. limit-1
// one entry per cycle, so ready stays low while that clearing runs. After
// reset a clearing pass runs over the whole count memory (NUM_PAGES entries,
// 65536 by default) with ready low; configuration writes are taken throughout.
// PAGE_BYTES must be a power of two; page_limit is used clamped to NUM_PAGES.
module page_allocator_with_refcounts
    import pa_pkg::*;
#(
    parameter int NUM_PAGES  = 65536,
    parameter int PAGE_BYTES = 4096,
    parameter int REF_BITS   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    pa_req_if.sink                req,
    pa_rsp_if.source              rsp
);

    // derived widths
    localparam int IDX_W    = $clog2(NUM_PAGES);
    localparam int CNT_W    = $clog2(NUM_PAGES + 1);
    localparam int OFFSET_W = $clog2(PAGE_BYTES);
    localparam int PAGE_W   = ADDR_W - OFFSET_W;
    localparam int CW_A     = (PAGE_W > CNT_W) ? PAGE_W : CNT_W;
    localparam int CW       = (CW_A > LIMIT_W) ? CW_A : LIMIT_W;
    localparam int SW       = ((REF_BITS > DELTA_W) ? REF_BITS : DELTA_W) + 2;

    localparam logic [CW-1:0]       NUM_PAGES_C = CW'(NUM_PAGES);
    localparam logic [REF_BITS-1:0] REF_ONE     = REF_BITS'(1);
    localparam logic [REF_BITS-1:0] REF_MAX     = {REF_BITS{1'b1}};

    // control states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // configuration registers
    logic [FIRST_W-1:0] first_page_reg;
    logic [LIMIT_W-1:0] page_limit_reg;

    // control and allocator state
    logic             state_reg, state_next;
    logic [CNT_W-1:0] stack_depth_reg, stack_depth_next;
    logic [CNT_W-1:0] bound_reg, bound_next;
    logic [CNT_W-1:0] free_pages_reg, free_pages_next;
    logic             out_valid_reg, out_valid_next;

    // latched request
    logic [OP_W-1:0]           op_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic signed [DELTA_W-1:0] delta_reg;

    // response registers
    logic [ADDR_W-1:0]   out_page_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [FCOUNT_W-1:0] out_fcount_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // freed page stack
    logic [IDX_W-1:0] stack_mem [NUM_PAGES];
    logic [IDX_W-1:0] stack_rd_reg;
    logic [CNT_W-1:0] stack_top;
    logic             stack_we;

    // count memory ports
    logic [IDX_W-1:0]    cnt_raddr;
    logic [REF_BITS-1:0] cnt_rd;
    logic                cnt_we;
    logic [IDX_W-1:0]    cnt_waddr;
    logic [REF_BITS-1:0] cnt_wdata;
    logic                clr_start;
    logic                clr_busy;

    // address and range arithmetic
    logic          accept;
    logic          exec_done;
    logic [CW-1:0] lim_w;
    logic [CW-1:0] first_w;
    logic [CW-1:0] in_page_w;
    logic [CW-1:0] cur_page_w;
    logic [CW-1:0] range_len;
    logic          range_ok;
    logic [CNT_W-1:0] bound_dec;
    logic [IDX_W-1:0] alloc_idx;
    logic [ADDR_W+IDX_W+OFFSET_W-1:0] alloc_wide;

    // saturating add
    logic signed [SW-1:0] cnt_s;
    logic signed [SW-1:0] delta_s;
    logic signed [SW-1:0] sum_s;
    logic [REF_BITS-1:0]  sat_count;

    // response assembly
    logic [REF_BITS-1:0]         res_count;
    logic [ADDR_W-1:0]           res_page;
    logic [STATUS_W-1:0]         res_status;
    logic [REF_BITS+VALUE_W-1:0] val_wide;
    logic [CNT_W+FCOUNT_W-1:0]   fc_wide;

    // handshakes
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !clr_busy;
    assign exec_done = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    assign rsp.valid        = out_valid_reg;
    assign rsp.page_address = out_page_reg;
    assign rsp.ref_value    = out_value_reg;
    assign rsp.free_count   = out_fcount_reg;
    assign rsp.status       = out_status_reg;

    // page limit is clamped to the table size
    assign lim_w      = (CW'(page_limit_reg) > NUM_PAGES_C) ? NUM_PAGES_C : CW'(page_limit_reg);
    assign first_w    = CW'(first_page_reg);
    assign in_page_w  = CW'(req.byte_address[ADDR_W-1:OFFSET_W]);
    assign cur_page_w = CW'(addr_reg[ADDR_W-1:OFFSET_W]);
    assign range_ok   = first_w < lim_w;
    assign range_len  = lim_w - first_w;

    // latched page is re-read while the execute step waits on the response side
    assign cnt_raddr  = accept ? in_page_w[IDX_W-1:0] : cur_page_w[IDX_W-1:0];

    // allocation source: freed stack first, then the untouched pages going down
    assign stack_top  = stack_depth_reg - CNT_W'(1);
    assign bound_dec  = bound_reg - CNT_W'(1);
    assign alloc_idx  = (stack_depth_reg != '0) ? stack_rd_reg : bound_dec[IDX_W-1:0];
    assign alloc_wide = {{ADDR_W{1'b0}}, alloc_idx, {OFFSET_W{1'b0}}};

    // count plus signed delta, clamped to the count range
    assign cnt_s     = SW'(cnt_rd);
    assign delta_s   = SW'(delta_reg);
    assign sum_s     = cnt_s + delta_s;
    assign sat_count = sum_s[SW-1] ? '0
                     : (sum_s[SW-2:0] > (SW-1)'(REF_MAX)) ? REF_MAX
                     : sum_s[REF_BITS-1:0];

    // freed stack memory, read at the top in the accept cycle
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_depth_reg[IDX_W-1:0]] <= cur_page_w[IDX_W-1:0];
        end
        stack_rd_reg <= stack_mem[stack_top[IDX_W-1:0]];
    end

    // count memory, read at the request page in the accept cycle
    pa_ref_store #(
        .NUM_PAGES (NUM_PAGES),
        .REF_BITS  (REF_BITS)
    ) u_ref_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (cnt_raddr),
        .rd_data   (cnt_rd),
        .wr_en     (cnt_we),
        .wr_addr   (cnt_waddr),
        .wr_data   (cnt_wdata),
        .clr_start (clr_start),
        .clr_first (first_w[CNT_W-1:0]),
        .clr_limit (lim_w[CNT_W-1:0]),
        .busy      (clr_busy)
    );

    // execute step: modify, write back, build the response
    always_comb
    begin
        state_next       = state_reg;
        stack_depth_next = stack_depth_reg;
        bound_next       = bound_reg;
        free_pages_next  = free_pages_reg;
        out_valid_next   = out_valid_reg;
        stack_we         = 1'b0;
        cnt_we           = 1'b0;
        cnt_waddr        = cur_page_w[IDX_W-1:0];
        cnt_wdata        = '0;
        clr_start        = 1'b0;
        res_count        = '0;
        res_page         = '0;
        res_status       = ST_OK;

        if (accept)
        begin
            state_next = S_EXEC;
        end
        else if (exec_done)
        begin
            state_next = S_IDLE;
        end

        if (exec_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (exec_done)
        begin
            unique case (op_reg)
                OP_INIT:
                begin
                    stack_depth_next = '0;
                    bound_next       = lim_w[CNT_W-1:0];
                    free_pages_next  = range_ok ? range_len[CNT_W-1:0] : '0;
                    clr_start        = range_ok;
                end
                OP_ALLOC:
                begin
                    priority if (stack_depth_reg != '0 || CW'(bound_reg) > first_w)
                    begin
                        if (stack_depth_reg != '0)
                        begin
                            stack_depth_next = stack_top;
                        end
                        else
                        begin
                            bound_next = bound_dec;
                        end
                        cnt_we    = 1'b1;
                        cnt_waddr = alloc_idx;
                        cnt_wdata = REF_ONE;
                        if (free_pages_reg != '0)
                        begin
                            free_pages_next = free_pages_reg - CNT_W'(1);
                        end
                        res_page  = alloc_wide[ADDR_W-1:0];
                        res_count = REF_ONE;
                    end
                    else
                    begin
                        res_status = ST_OUT_OF_MEMORY;
                    end
                end
                OP_FREE:
                begin
                    priority if (addr_reg[OFFSET_W-1:0] != '0 || cur_page_w < first_w
                                 || cur_page_w >= lim_w)
                    begin
                        res_status = ST_BAD_FREE;
                    end
                    else if (CW'(stack_depth_reg) >= NUM_PAGES_C
                             || CW'(free_pages_reg) >= NUM_PAGES_C)
                    begin
                        res_status = ST_STACK_FULL;
                    end
                    else
                    begin
                        // still freed when the count is off, only flagged
                        res_status       = (cnt_rd != REF_ONE) ? ST_COUNT_NOT_ONE : ST_OK;
                        stack_we         = 1'b1;
                        stack_depth_next = stack_depth_reg + CNT_W'(1);
                        free_pages_next  = free_pages_reg + CNT_W'(1);
                        cnt_we           = 1'b1;
                        cnt_wdata        = '0;
                    end
                end
                OP_ADD:
                begin
                    if (cur_page_w >= NUM_PAGES_C)
                    begin
                        res_status = ST_OUTSIDE_TABLE;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = sat_count;
                        res_count = sat_count;
                    end
                end
                OP_READ:
                begin
                    if (cur_page_w >= NUM_PAGES_C)
                    begin
                        res_status = ST_OUTSIDE_TABLE;
                    end
                    else
                    begin
                        res_count = cnt_rd;
                    end
                end
                default:
                begin
                    // unknown operation: no change, plain ok response
                    res_status = ST_OK;
                end
            endcase
        end
    end

    assign val_wide = {{VALUE_W{1'b0}}, res_count};
    assign fc_wide  = {{FCOUNT_W{1'b0}}, free_pages_next};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg  <= '0;
            page_limit_reg  <= PAGE_LIMIT_RESET;
            state_reg       <= S_IDLE;
            stack_depth_reg <= '0;
            bound_reg       <= '0;
            free_pages_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_FIRST_PAGE: first_page_reg <= cfg_wdata[FIRST_W-1:0];
                    CFG_PAGE_LIMIT: page_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                endcase
            end
            state_reg       <= state_next;
            stack_depth_reg <= stack_depth_next;
            bound_reg       <= bound_next;
            free_pages_reg  <= free_pages_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.operation;
            addr_reg  <= req.byte_address;
            delta_reg <= req.ref_delta;
        end
        if (exec_done)
        begin
            out_page_reg   <= res_page;
            out_value_reg  <= val_wide[VALUE_W-1:0];
            out_fcount_reg <= fc_wide[FCOUNT_W-1:0];
            out_status_reg <= res_status;
        end
    end

`ifndef SYNTH
    // every stacked page is counted as free
    a_depth_within_free: assert property (@(posedge clk) disable iff (!rst_n)
        stack_depth_reg <= free_pages_reg)
        else $error("freed stack deeper than free page count");

    // no request transaction while the count memory is being cleared
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !req.ready)
        else $error("request ready during count clearing");

    // a response appears only out of the execute step
    a_response_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response raised without an execute step");
`endif

endmodule

`default_nettype wire

// ===== bench/page_allocator_with_refcounts_checker.sv =====
// transaction monitor, page allocator model and response comparison for the page allocator bench
`timescale 1ns / 1ps

module page_allocator_with_refcounts_checker
    import pa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    pa_req_if                     req,
    pa_rsp_if                     rsp,
    output int unsigned           failures,
    output int unsigned           pending
);

    localparam int unsigned PAGE_COUNT = 65536;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int          COUNT_MAX  = 255;
    localparam int unsigned REPORT_CAP = 40;

    typedef struct packed {
        logic [ADDR_W-1:0]   page_address;
        logic [VALUE_W-1:0]  ref_value;
        logic [FCOUNT_W-1:0] free_count;
        logic [STATUS_W-1:0] status;
    } page_reply_t;

    // allocator state as the block should hold it
    logic [VALUE_W-1:0] page_refs   [PAGE_COUNT];
    logic [15:0]        freed_pages [PAGE_COUNT];
    int unsigned        freed_depth;
    int unsigned        fresh_bound;
    int unsigned        free_total;
    int unsigned        first_pg;
    int unsigned        limit_pg;

    page_reply_t        owed_responses [$];
    page_reply_t        want;
    int unsigned        reported;

    function automatic void clear_allocator();
        int unsigned i;
        for (i = 0; i < PAGE_COUNT; i++)
        begin
            page_refs[i]   = '0;
            freed_pages[i] = '0;
        end
        freed_depth = 0;
        fresh_bound = 0;
        free_total  = 0;
        first_pg    = 0;
        limit_pg    = PAGE_LIMIT_RESET;
        owed_responses.delete();
    endfunction

    function automatic page_reply_t apply_page_op(input logic [OP_W-1:0]           op,
                                                  input logic [ADDR_W-1:0]         addr,
                                                  input logic signed [DELTA_W-1:0] delta);
        page_reply_t res;
        int unsigned page;
        int unsigned lim;
        int unsigned p;
        int unsigned i;
        int          level;
        bit          got;
        res  = '0;
        got  = 1'b0;
        p    = 0;
        page = addr >> PAGE_SHIFT;
        lim  = (limit_pg > PAGE_COUNT) ? PAGE_COUNT : limit_pg;
        case (op)
            OP_INIT:
            begin
                freed_depth = 0;
                fresh_bound = lim;
                for (i = first_pg; i < lim; i++)
                    page_refs[i] = '0;
                free_total = (lim > first_pg) ? lim - first_pg : 0;
            end
            OP_ALLOC:
            begin
                // freed pages are reused first, then the untouched region top down
                if (freed_depth > 0)
                begin
                    freed_depth--;
                    p   = freed_pages[freed_depth] % PAGE_COUNT;
                    got = 1'b1;
                end
                else if (fresh_bound > first_pg && fresh_bound > 0)
                begin
                    fresh_bound--;
                    p   = fresh_bound % PAGE_COUNT;
                    got = 1'b1;
                end
                if (got)
                begin
                    page_refs[p] = 1;
                    if (free_total > 0)
                        free_total--;
                    res.page_address = ADDR_W'(p << PAGE_SHIFT);
                    res.ref_value    = 1;
                end
                else
                    res.status = ST_OUT_OF_MEMORY;
            end
            OP_FREE:
            begin
                if (addr[PAGE_SHIFT-1:0] != '0 || page < first_pg || page >= lim)
                    res.status = ST_BAD_FREE;
                else if (freed_depth >= PAGE_COUNT || free_total >= PAGE_COUNT)
                    res.status = ST_STACK_FULL;
                else
                begin
                    if (page_refs[page] != 1)
                        res.status = ST_COUNT_NOT_ONE;
                    freed_pages[freed_depth] = 16'(page);
                    freed_depth++;
                    free_total++;
                    page_refs[page] = '0;
                end
            end
            OP_ADD:
            begin
                if (page >= PAGE_COUNT)
                    res.status = ST_OUTSIDE_TABLE;
                else
                begin
                    level = int'(page_refs[page]) + int'(delta);
                    if (level < 0)
                        level = 0;
                    if (level > COUNT_MAX)
                        level = COUNT_MAX;
                    page_refs[page] = VALUE_W'(level);
                    res.ref_value   = VALUE_W'(level);
                end
            end
            OP_READ:
            begin
                if (page >= PAGE_COUNT)
                    res.status = ST_OUTSIDE_TABLE;
                else
                    res.ref_value = page_refs[page];
            end
            default: ;
        endcase
        res.free_count = FCOUNT_W'(free_total);
        return res;
    endfunction

    function automatic void report_mismatch(input string field, input logic [31:0] exp_v,
                                            input logic [31:0] act_v);
        failures++;
        if (reported < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        reported++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_allocator();
            failures = 0;
            reported = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_index == CFG_FIRST_PAGE)
                    first_pg = cfg_wdata[FIRST_W-1:0];
                else if (cfg_index == CFG_PAGE_LIMIT)
                    limit_pg = cfg_wdata[LIMIT_W-1:0];
            end
            // the response of this edge always belongs to an earlier request
            if (rsp.valid && rsp.ready)
            begin
                if (owed_responses.size() == 0)
                    report_mismatch("unrequested response status", '0, rsp.status);
                else
                begin
                    want = owed_responses.pop_front();
                    if (rsp.page_address !== want.page_address)
                        report_mismatch("page_address", want.page_address, rsp.page_address);
                    if (rsp.ref_value !== want.ref_value)
                        report_mismatch("ref_value", want.ref_value, rsp.ref_value);
                    if (rsp.free_count !== want.free_count)
                        report_mismatch("free_count", want.free_count, rsp.free_count);
                    if (rsp.status !== want.status)
                        report_mismatch("status", want.status, rsp.status);
                end
            end
            if (req.valid && req.ready)
                owed_responses.push_back(apply_page_op(req.operation, req.byte_address,
                                                       req.ref_delta));
            pending <= owed_responses.size();
        end
    end

endmodule

// ===== bench/page_allocator_with_refcounts_test.sv =====
// top of the page allocator bench: clock, reset, request stimulus, response stalls and verdict
`timescale 1ns / 1ps

module page_allocator_with_refcounts_test;
    import pa_pkg::*;

    localparam int unsigned PAGE_COUNT    = 65536;
    localparam int unsigned PAGE_SHIFT    = 12;
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned IDLE_PERCENT  = 18;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned RANDOM_ITEMS  = 600;
    // two full-table clears plus the reset-default clear, far below this
    localparam int unsigned LIMIT_CYCLES  = 2000000;

    // codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

    localparam logic signed [DELTA_W-1:0] DELTA_MAX  = 8'sd127;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN  = -8'sd128;
    localparam logic signed [DELTA_W-1:0] DELTA_NONE = 8'sd0;
    localparam logic [ADDR_W-1:0]         ADDR_TOP   = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0]         ADDR_ZERO  = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // no random idling on either side while this is set
    logic                  steady;

    int unsigned           failures;
    int unsigned           pending;
    int unsigned           sent_count;
    int unsigned           range_count;
    int unsigned           cycle_count;
    int unsigned           cur_first;
    int unsigned           cur_limit;

    pa_req_if req ();
    pa_rsp_if rsp ();

    page_allocator_with_refcounts u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    page_allocator_with_refcounts_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost response ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped by the watchdog after %0d cycles, %0d responses outstanding",
                 cycle_count, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // response side: ready drops at random, with odds of IDLE_PERCENT in a hundred
    initial
        rsp.ready = 1'b0;

    always @(posedge clk)
        rsp.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

    function automatic logic [ADDR_W-1:0] page_addr(input int unsigned page);
        return ADDR_W'(page << PAGE_SHIFT);
    endfunction

    // one request transaction; valid is left high after acceptance so that a
    // following call can present its item at once without a gap
    task automatic send_request(input logic [OP_W-1:0]           op,
                                input logic [ADDR_W-1:0]         addr,
                                input logic signed [DELTA_W-1:0] delta);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.operation    <= op;
        req.byte_address <= addr;
        req.ref_delta    <= delta;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        sent_count++;
    endtask

    // stop sending and wait until every response is back and the block takes
    // requests again (init keeps ready low while it clears its range)
    task automatic drain_requests();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || req.ready !== 1'b1)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers back to back, only ever called with the block idle
    task automatic program_range(input int unsigned first, input int unsigned limit);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_FIRST_PAGE;
        cfg_wdata <= CFG_DATA_W'(first);
        @(posedge clk);
        cfg_index <= CFG_PAGE_LIMIT;
        cfg_wdata <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        @(posedge clk);
        cur_first = first;
        cur_limit = limit;
        range_count++;
    endtask

    // mostly well-formed traffic inside the configured range, the rest noise
    task automatic random_item();
        logic [31:0]               r32;
        logic [ADDR_W-1:0]         noise;
        logic [ADDR_W-1:0]         target;
        logic signed [DELTA_W-1:0] delta;
        logic [OP_W-1:0]           odd_op;
        int unsigned               span;
        int unsigned               pick;
        r32    = $urandom();
        noise  = r32[ADDR_W-1:0];
        r32    = $urandom();
        delta  = r32[DELTA_W-1:0];
        odd_op = OP_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        span   = (cur_limit > cur_first) ? cur_limit - cur_first : 1;
        target = page_addr(cur_first + $urandom_range(0, span - 1));
        pick   = $urandom_range(0, 99);
        if (pick < 32)
            send_request(OP_ALLOC, noise, delta);
        else if (pick < 60)
            send_request(OP_FREE, target, delta);
        else if (pick < 72)
            send_request(OP_ADD, target, delta);
        else if (pick < 82)
            send_request(OP_READ, target, delta);
        else if (pick < 86)
            send_request(OP_INIT, noise, delta);
        else if (pick < 90)
            send_request(OP_FREE, noise, delta);
        else if (pick < 94)
            send_request(OP_ADD, noise, delta);
        else if (pick < 97)
            send_request(OP_READ, noise, delta);
        else
            send_request(odd_op, noise, delta);
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned phase_len;
        int unsigned k;
        int unsigned first;
        int unsigned limit;
        int unsigned pick;
        int unsigned target_items;
        logic [31:0] r32;

        req.valid        = 1'b0;
        req.operation    = OP_INIT;
        req.byte_address = '0;
        req.ref_delta    = '0;
        cfg_wen          = 1'b0;
        cfg_index        = CFG_FIRST_PAGE;
        cfg_wdata        = '0;
        steady           = 1'b0;
        sent_count       = 0;
        range_count      = 0;
        cur_first        = 0;
        cur_limit        = PAGE_LIMIT_RESET;
        rst_n            = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // the block clears its whole count table after reset before it takes anything
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);

        // directed, first with the reset values of both registers
        send_request(OP_READ, ADDR_TOP, DELTA_NONE);          // top page, count cleared by reset
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);        // nothing free before any init
        send_request(OP_FREE, page_addr(5), DELTA_NONE);      // free of a page with count zero
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);        // comes back from the freed stack
        send_request(OP_INIT, ADDR_ZERO, DELTA_NONE);
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);        // highest page below the limit
        send_request(OP_ADD, page_addr(57343), DELTA_MAX);
        send_request(OP_ADD, page_addr(57343), DELTA_MAX);
        send_request(OP_ADD, page_addr(57343), DELTA_MAX);    // saturates at the top
        send_request(OP_ADD, page_addr(57343), DELTA_MIN);
        send_request(OP_ADD, page_addr(57343), DELTA_MIN);    // saturates at zero
        send_request(OP_FREE, page_addr(57343), DELTA_NONE);  // count not one
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);
        send_request(OP_FREE, page_addr(57343), DELTA_NONE);  // clean free
        send_request(OP_FREE, page_addr(57343) | 28'h801, DELTA_NONE);  // unaligned
        send_request(OP_FREE, page_addr(57344), DELTA_NONE);  // at the limit
        send_request(OP_UNKNOWN_HI, ADDR_TOP, DELTA_MIN);
        drain_requests();

        // single page at the very top of the table
        program_range(PAGE_COUNT - 1, PAGE_COUNT);
        send_request(OP_INIT, ADDR_ZERO, DELTA_NONE);
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);        // out of memory
        send_request(OP_FREE, page_addr(0), DELTA_NONE);      // below first page
        send_request(OP_FREE, page_addr(PAGE_COUNT - 1), DELTA_NONE);
        drain_requests();

        // whole table: every page free, so one more free finds the stack full
        program_range(0, PAGE_COUNT);
        send_request(OP_INIT, ADDR_ZERO, DELTA_NONE);
        send_request(OP_FREE, page_addr(0), DELTA_NONE);
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);
        drain_requests();

        // single page at the bottom, page zero gives address zero
        program_range(0, 1);
        send_request(OP_INIT, ADDR_ZERO, DELTA_NONE);
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);
        send_request(OP_ALLOC, ADDR_ZERO, DELTA_NONE);

        // random phases, each on a fresh small range, mostly starting with an init
        target_items = sent_count + RANDOM_ITEMS;
        phase = 0;
        while (sent_count < target_items)
        begin
            drain_requests();
            steady <= (phase == 4 || phase == 5);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                first = 0;
                limit = $urandom_range(1, 24);
            end
            else if (pick == 1)
            begin
                limit = PAGE_COUNT;
                first = PAGE_COUNT - $urandom_range(1, 24);
            end
            else if (pick == 2)
            begin
                // empty range: first at or above the limit
                first = $urandom_range(1, PAGE_COUNT - 1);
                limit = $urandom_range(1, first);
            end
            else
            begin
                first = $urandom_range(0, 65500);
                limit = first + $urandom_range(1, 32);
            end
            program_range(first, limit);
            r32 = $urandom();
            if ($urandom_range(0, 4) != 0)
                send_request(OP_INIT, r32[ADDR_W-1:0], r32[31:24]);
            phase_len = $urandom_range(25, 60);
            for (k = 0; k < phase_len; k++)
            begin
                // now and then hold off until the block has answered everything
                if ($urandom_range(0, 99) < 2)
                    drain_requests();
                random_item();
            end
            phase++;
        end

        steady <= 1'b0;
        drain_requests();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d request transactions over %0d register settings in %0d cycles",
                 sent_count, range_count, cycle_count);
        $display("ranges: reset defaults, full table, top and bottom single pages, empty, random");
        if (failures == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pa_pkg.sv
rtl/pa_req_if.sv
rtl/pa_rsp_if.sv
rtl/pa_ref_store.sv
rtl/page_allocator_with_refcounts.sv
bench/page_allocator_with_refcounts_checker.sv
bench/page_allocator_with_refcounts_test.sv
